[rtl/timed_sweep_actuator_sequencer_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the timed sweep actuator sequencer
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TIMED_SWEEP_ACTUATOR_SEQUENCER_ASSERT_SVH
`define TIMED_SWEEP_ACTUATOR_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define TSAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tsas_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsas_pkg
// Shared types and constants of the timed sweep actuator sequencer.
// ---------------------------------------------------------------------------
package tsas_pkg;

  localparam int unsigned CFG_W      = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned TMO_W      = 20;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned ELAPSED_W  = 8;
  localparam int unsigned PTIME_W    = 17;
  localparam int unsigned TTIME_W    = 21;

  localparam logic [ELAPSED_W-1:0] MAX_TICK_MS = 8'd100;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_PUSH    = 3'd2,
    PH_HOLD    = 3'd3,
    PH_RETRACT = 3'd4,
    PH_BETWEEN = 3'd5,
    PH_DONE    = 3'd6,
    PH_FAILED  = 3'd7
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE   = 3'd0,
    REG_PUSH_OUT = 3'd1,
    REG_HOLD     = 3'd2,
    REG_CAPTURE  = 3'd3,
    REG_RETRACT  = 3'd4,
    REG_BETWEEN  = 3'd5,
    REG_TIMEOUT  = 3'd6,
    REG_SWEEPS   = 3'd7
  } reg_idx_t;

  localparam logic [DUR_W-1:0] SETTLE_RST   = 16'd500;
  localparam logic [DUR_W-1:0] PUSH_OUT_RST = 16'd500;
  localparam logic [DUR_W-1:0] HOLD_RST     = 16'd500;
  localparam logic [DUR_W-1:0] CAPTURE_RST  = 16'd100;
  localparam logic [DUR_W-1:0] RETRACT_RST  = 16'd500;
  localparam logic [DUR_W-1:0] BETWEEN_RST  = 16'd200;
  localparam logic [TMO_W-1:0] TIMEOUT_RST  = 20'd10000;
  localparam logic [CNT_W-1:0] SWEEPS_RST   = 8'd1;

  typedef struct packed {
    logic [DUR_W-1:0] settle_ms;
    logic [DUR_W-1:0] push_out_ms;
    logic [DUR_W-1:0] hold_ms;
    logic [DUR_W-1:0] capture_wait_ms;
    logic [DUR_W-1:0] retract_ms;
    logic [DUR_W-1:0] between_ms;
    logic [TMO_W-1:0] timeout_ms;
    logic [CNT_W-1:0] sweep_count;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic             finished;
    logic             success;
    logic             push_active;
    logic [CNT_W-1:0] sweeps;
  } status_t;

endpackage

[rtl/tsas_cfg_regs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsas_cfg_regs
// Write-only configuration registers of the sweep sequencer.
// ---------------------------------------------------------------------------
module tsas_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tsas_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tsas_pkg::CFG_W-1:0]      cfg_wdata,
  output tsas_pkg::cfg_t                  cfg
);

  tsas_pkg::cfg_t cfg_r;
  tsas_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (tsas_pkg::reg_idx_t'(cfg_idx))
        tsas_pkg::REG_SETTLE:   cfg_nxt.settle_ms       = cfg_wdata[tsas_pkg::DUR_W-1:0];
        tsas_pkg::REG_PUSH_OUT: cfg_nxt.push_out_ms     = cfg_wdata[tsas_pkg::DUR_W-1:0];
        tsas_pkg::REG_HOLD:     cfg_nxt.hold_ms         = cfg_wdata[tsas_pkg::DUR_W-1:0];
        tsas_pkg::REG_CAPTURE:  cfg_nxt.capture_wait_ms = cfg_wdata[tsas_pkg::DUR_W-1:0];
        tsas_pkg::REG_RETRACT:  cfg_nxt.retract_ms      = cfg_wdata[tsas_pkg::DUR_W-1:0];
        tsas_pkg::REG_BETWEEN:  cfg_nxt.between_ms      = cfg_wdata[tsas_pkg::DUR_W-1:0];
        tsas_pkg::REG_TIMEOUT:  cfg_nxt.timeout_ms      = cfg_wdata[tsas_pkg::TMO_W-1:0];
        tsas_pkg::REG_SWEEPS:   cfg_nxt.sweep_count     = cfg_wdata[tsas_pkg::CNT_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ms       <= tsas_pkg::SETTLE_RST;
      cfg_r.push_out_ms     <= tsas_pkg::PUSH_OUT_RST;
      cfg_r.hold_ms         <= tsas_pkg::HOLD_RST;
      cfg_r.capture_wait_ms <= tsas_pkg::CAPTURE_RST;
      cfg_r.retract_ms      <= tsas_pkg::RETRACT_RST;
      cfg_r.between_ms      <= tsas_pkg::BETWEEN_RST;
      cfg_r.timeout_ms      <= tsas_pkg::TIMEOUT_RST;
      cfg_r.sweep_count     <= tsas_pkg::SWEEPS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/tsas_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsas_core
// Phase state machine, timers and sweep counter; applies one request when
// fire is high and presents the status after that request.
// ---------------------------------------------------------------------------
module tsas_core #(
  parameter logic [tsas_pkg::ELAPSED_W-1:0] MAX_TICK_MS = tsas_pkg::MAX_TICK_MS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  tsas_pkg::opcode_t                opcode,
  input  logic [tsas_pkg::ELAPSED_W-1:0]   elapsed_ms,
  input  logic                             captured,
  input  tsas_pkg::cfg_t                   cfg,
  output tsas_pkg::status_t                status_nxt
);

  tsas_pkg::phase_t                 phase_r, phase_nxt;
  logic [tsas_pkg::PTIME_W-1:0]     ptime_r, ptime_nxt;
  logic [tsas_pkg::TTIME_W-1:0]     ttime_r, ttime_nxt;
  logic [tsas_pkg::CNT_W-1:0]       sweeps_r, sweeps_nxt;
  logic                             done_r, done_nxt;
  logic                             succ_r, succ_nxt;
  logic                             cancel_r, cancel_nxt;

  logic [tsas_pkg::ELAPSED_W-1:0]   dt;
  logic [tsas_pkg::PTIME_W:0]       ptime_sum;
  logic [tsas_pkg::TTIME_W:0]       ttime_sum;
  logic [tsas_pkg::PTIME_W-1:0]     ptime_sat;
  logic [tsas_pkg::TTIME_W-1:0]     ttime_sat;
  logic [tsas_pkg::DUR_W-1:0]       hold_dur;
  logic [tsas_pkg::CNT_W-1:0]       sweeps_inc;

  assign dt = (elapsed_ms > MAX_TICK_MS) ? MAX_TICK_MS : elapsed_ms;
  assign ptime_sum = {1'b0, ptime_r} + {{(tsas_pkg::PTIME_W+1-tsas_pkg::ELAPSED_W){1'b0}}, dt};
  assign ttime_sum = {1'b0, ttime_r} + {{(tsas_pkg::TTIME_W+1-tsas_pkg::ELAPSED_W){1'b0}}, dt};
  assign ptime_sat = ptime_sum[tsas_pkg::PTIME_W] ? '1 : ptime_sum[tsas_pkg::PTIME_W-1:0];
  assign ttime_sat = ttime_sum[tsas_pkg::TTIME_W] ? '1 : ttime_sum[tsas_pkg::TTIME_W-1:0];
  assign hold_dur  = captured ? cfg.capture_wait_ms : cfg.hold_ms;
  assign sweeps_inc = (sweeps_r == '1) ? sweeps_r : sweeps_r + 8'd1;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    ptime_nxt  = ptime_r;
    ttime_nxt  = ttime_r;
    sweeps_nxt = sweeps_r;
    done_nxt   = done_r;
    succ_nxt   = succ_r;
    cancel_nxt = cancel_r;
    case (opcode)
      tsas_pkg::OP_TICK: begin
        if (!done_r && phase_r != tsas_pkg::PH_IDLE) begin
          ttime_nxt = ttime_sat;
          ptime_nxt = ptime_sat;
          if (ttime_sat >= {1'b0, cfg.timeout_ms}) begin
            done_nxt  = 1'b1;
            succ_nxt  = 1'b0;
            phase_nxt = tsas_pkg::PH_FAILED;
            ptime_nxt = '0;
          end else begin
            case (phase_r)
              tsas_pkg::PH_SETTLE: begin
                if (ptime_sat >= {1'b0, cfg.settle_ms}) begin
                  phase_nxt = tsas_pkg::PH_PUSH;
                  ptime_nxt = '0;
                end
              end
              tsas_pkg::PH_PUSH: begin
                if (ptime_sat >= {1'b0, cfg.push_out_ms}) begin
                  phase_nxt = tsas_pkg::PH_HOLD;
                  ptime_nxt = '0;
                end
              end
              tsas_pkg::PH_HOLD: begin
                if (ptime_sat >= {1'b0, hold_dur}) begin
                  phase_nxt = tsas_pkg::PH_RETRACT;
                  ptime_nxt = '0;
                end
              end
              tsas_pkg::PH_RETRACT: begin
                if (ptime_sat >= {1'b0, cfg.retract_ms}) begin
                  sweeps_nxt = sweeps_inc;
                  ptime_nxt  = '0;
                  if (sweeps_inc >= cfg.sweep_count) begin
                    done_nxt  = 1'b1;
                    succ_nxt  = !cancel_r;
                    phase_nxt = tsas_pkg::PH_DONE;
                  end else begin
                    phase_nxt = tsas_pkg::PH_BETWEEN;
                  end
                end
              end
              tsas_pkg::PH_BETWEEN: begin
                if (ptime_sat >= {1'b0, cfg.between_ms}) begin
                  phase_nxt = tsas_pkg::PH_PUSH;
                  ptime_nxt = '0;
                end
              end
              default: begin
                phase_nxt = phase_r;
              end
            endcase
          end
        end
      end
      tsas_pkg::OP_START: begin
        cancel_nxt = 1'b0;
        done_nxt   = 1'b0;
        succ_nxt   = 1'b0;
        ttime_nxt  = '0;
        sweeps_nxt = '0;
        phase_nxt  = tsas_pkg::PH_SETTLE;
        ptime_nxt  = '0;
      end
      tsas_pkg::OP_CANCEL: begin
        cancel_nxt = 1'b1;
        done_nxt   = 1'b1;
        succ_nxt   = 1'b0;
        phase_nxt  = tsas_pkg::PH_FAILED;
        ptime_nxt  = '0;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // outputs
  always_comb begin
    status_nxt.phase       = phase_nxt;
    status_nxt.finished    = done_nxt;
    status_nxt.success     = succ_nxt;
    status_nxt.push_active = (phase_nxt == tsas_pkg::PH_PUSH) ||
                             (phase_nxt == tsas_pkg::PH_HOLD);
    status_nxt.sweeps      = sweeps_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tsas_pkg::PH_IDLE;
      ptime_r  <= '0;
      ttime_r  <= '0;
      sweeps_r <= '0;
      done_r   <= 1'b0;
      succ_r   <= 1'b0;
      cancel_r <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      ptime_r  <= ptime_nxt;
      ttime_r  <= ttime_nxt;
      sweeps_r <= sweeps_nxt;
      done_r   <= done_nxt;
      succ_r   <= succ_nxt;
      cancel_r <= cancel_nxt;
    end
  end

endmodule

[rtl/timed_sweep_actuator_sequencer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// timed_sweep_actuator_sequencer
// Settle / push / hold / retract / pause sweep sequencer with timeout.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request per valid/ready handshake, opcode
//   tick, start or cancel; a tick carries elapsed milliseconds (clamped to
//   MAX_TICK_MS, 100 by default) and the capture sensor flag.
//   Output channel (out_*): exactly one status per request, giving the
//   phase, finished, success, push-active and the sweeps completed so far.
//   Config port (cfg_*): single-cycle writes of the eight timing and count
//   registers, to be made while no request is in flight.
//   Path: the input handshake fills the input register; out_valid rises
//   once its status lands in the output register. Throughput: one request
//   per cycle while out_ready is high; the phase logic lies between them.
//   Stall: while out_ready is low the output holds, one more request may
//   wait in the input register, then in_ready drops.
//   Reset: synchronous, clears both pipeline valid flags, returns the phase
//   to idle with timers and counters zeroed and loads the register defaults.
// ---------------------------------------------------------------------------
module timed_sweep_actuator_sequencer #(
  parameter logic [tsas_pkg::ELAPSED_W-1:0] MAX_TICK_MS = tsas_pkg::MAX_TICK_MS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tsas_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tsas_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic [tsas_pkg::ELAPSED_W-1:0]   in_elapsed_ms,
  input  logic                             in_captured,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_phase_code,
  output logic                             out_finished,
  output logic                             out_success,
  output logic                             out_push_active,
  output logic [tsas_pkg::CNT_W-1:0]       out_sweeps_completed
);

  tsas_pkg::cfg_t                   cfg;
  tsas_pkg::status_t                status_nxt;

  logic                             s1_valid_r, s1_valid_nxt;
  tsas_pkg::opcode_t                s1_op_r;
  logic [tsas_pkg::ELAPSED_W-1:0]   s1_elapsed_r;
  logic                             s1_capt_r;
  logic                             out_valid_r, out_valid_nxt;
  tsas_pkg::status_t                out_stat_r;

  logic                             advance;
  logic                             in_fire;
  logic                             core_fire;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign core_fire = s1_valid_r && advance;

  tsas_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tsas_core #(
    .MAX_TICK_MS (MAX_TICK_MS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (core_fire),
    .opcode        (s1_op_r),
    .elapsed_ms    (s1_elapsed_r),
    .captured      (s1_capt_r),
    .cfg           (cfg),
    .status_nxt    (status_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (core_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (core_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= tsas_pkg::opcode_t'(in_opcode);
      s1_elapsed_r <= in_elapsed_ms;
      s1_capt_r    <= in_captured;
    end
    if (core_fire) begin
      out_stat_r <= status_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_phase_code       = out_stat_r.phase;
  assign out_finished         = out_stat_r.finished;
  assign out_success          = out_stat_r.success;
  assign out_push_active      = out_stat_r.push_active;
  assign out_sweeps_completed = out_stat_r.sweeps;

endmodule

[rtl/tsas_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsas_checker
// Port-level checks of the sweep sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "timed_sweep_actuator_sequencer_assert.svh"

module tsas_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [2:0]                       out_phase_code,
  input  logic                             out_finished,
  input  logic                             out_success,
  input  logic                             out_push_active,
  input  logic [tsas_pkg::CNT_W-1:0]       out_sweeps_completed
);

  `TSAS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_phase_code) && $stable(out_finished) && $stable(out_success) && $stable(out_sweeps_completed), "stalled status changed")

  `TSAS_ASSERT_NOW(a_finished, out_valid, out_finished == ((out_phase_code == tsas_pkg::PH_DONE) || (out_phase_code == tsas_pkg::PH_FAILED)), "finished flag disagrees with phase")

  `TSAS_ASSERT_NOW(a_push, out_valid, out_push_active == ((out_phase_code == tsas_pkg::PH_PUSH) || (out_phase_code == tsas_pkg::PH_HOLD)), "push-active disagrees with phase")

  `TSAS_ASSERT_NOW(a_success, out_valid && out_success, out_phase_code == tsas_pkg::PH_DONE, "success outside done")

  `TSAS_ASSERT_NOW(a_ready, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind timed_sweep_actuator_sequencer tsas_checker u_tsas_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed sweep actuator sequencer. A behavioural
// copy of the sweep sequence predicts one status per accepted request; a
// monitor on the status channel compares every field in order. Directed
// cases cover idle, cancel, zero timeout, zero sweep count, early release
// of the hold on capture, the largest register values and one long receiver
// hold-off. A long run then drives the sweep counter to its top, followed by
// randomised sequences under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [tsas_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tsas_pkg::CFG_W-1:0]     cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     in_opcode;
  logic [tsas_pkg::ELAPSED_W-1:0] in_elapsed_ms;
  logic                           in_captured;
  logic                           out_valid;
  logic                           out_ready;
  logic [2:0]                     out_phase_code;
  logic                           out_finished;
  logic                           out_success;
  logic                           out_push_active;
  logic [tsas_pkg::CNT_W-1:0]     out_sweeps_completed;

  timed_sweep_actuator_sequencer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_elapsed_ms        (in_elapsed_ms),
    .in_captured          (in_captured),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_phase_code       (out_phase_code),
    .out_finished         (out_finished),
    .out_success          (out_success),
    .out_push_active      (out_push_active),
    .out_sweeps_completed (out_sweeps_completed)
  );

  // sequence state as the block should hold it
  tsas_pkg::cfg_t                 seq_cfg;
  tsas_pkg::phase_t               seq_phase;
  logic [tsas_pkg::PTIME_W-1:0]   seq_phase_ms;
  logic [tsas_pkg::TTIME_W-1:0]   seq_total_ms;
  logic [tsas_pkg::CNT_W-1:0]     seq_sweeps;
  logic                           seq_done;
  logic                           seq_success;
  logic                           seq_cancelled;

  tsas_pkg::status_t expected_status[$];

  int unsigned gap_max;
  int unsigned stall_max;
  int unsigned holdoff_req;
  int unsigned burst_left;
  int unsigned live_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned config_count;
  int unsigned input_stalls;
  int unsigned mismatches;
  int unsigned cycle_count;
  logic [7:0]  phases_seen;
  bit          valid_up;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d status(es) outstanding", $time,
               expected_status.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- prediction ----

  function automatic int unsigned clamp_add(int unsigned a, int unsigned b,
                                            int unsigned ceiling);
    return (a + b > ceiling) ? ceiling : a + b;
  endfunction

  function automatic tsas_pkg::status_t advance_sequence(
      tsas_pkg::opcode_t op, logic [tsas_pkg::ELAPSED_W-1:0] el, logic cap);
    int unsigned                dt;
    logic [tsas_pkg::DUR_W-1:0] hold_limit;
    tsas_pkg::phase_t           nxt;
    tsas_pkg::status_t          s;
    dt = (el > tsas_pkg::MAX_TICK_MS) ? tsas_pkg::MAX_TICK_MS : el;
    nxt = seq_phase;
    case (op)
      tsas_pkg::OP_TICK: begin
        if (!seq_done && seq_phase != tsas_pkg::PH_IDLE) begin
          seq_total_ms = tsas_pkg::TTIME_W'(clamp_add(seq_total_ms, dt,
                                                      (1 << tsas_pkg::TTIME_W) - 1));
          seq_phase_ms = tsas_pkg::PTIME_W'(clamp_add(seq_phase_ms, dt,
                                                      (1 << tsas_pkg::PTIME_W) - 1));
          hold_limit = cap ? seq_cfg.capture_wait_ms : seq_cfg.hold_ms;
          // timeout wins over any phase advance on the same tick
          if (seq_total_ms >= seq_cfg.timeout_ms) begin
            seq_done = 1'b1;
            seq_success = 1'b0;
            nxt = tsas_pkg::PH_FAILED;
          end else begin
            case (seq_phase)
              tsas_pkg::PH_SETTLE: begin
                if (seq_phase_ms >= seq_cfg.settle_ms) nxt = tsas_pkg::PH_PUSH;
              end
              tsas_pkg::PH_PUSH: begin
                if (seq_phase_ms >= seq_cfg.push_out_ms) nxt = tsas_pkg::PH_HOLD;
              end
              tsas_pkg::PH_HOLD: begin
                if (seq_phase_ms >= hold_limit) nxt = tsas_pkg::PH_RETRACT;
              end
              tsas_pkg::PH_RETRACT: begin
                if (seq_phase_ms >= seq_cfg.retract_ms) begin
                  if (seq_sweeps != 8'hFF) seq_sweeps++;
                  if (seq_sweeps >= seq_cfg.sweep_count) begin
                    seq_done = 1'b1;
                    seq_success = !seq_cancelled;
                    nxt = tsas_pkg::PH_DONE;
                  end else begin
                    nxt = tsas_pkg::PH_BETWEEN;
                  end
                end
              end
              tsas_pkg::PH_BETWEEN: begin
                if (seq_phase_ms >= seq_cfg.between_ms) nxt = tsas_pkg::PH_PUSH;
              end
              default: ;
            endcase
          end
          if (nxt != seq_phase) begin
            seq_phase = nxt;
            seq_phase_ms = '0;
          end
        end
      end
      tsas_pkg::OP_START: begin
        seq_cancelled = 1'b0;
        seq_done = 1'b0;
        seq_success = 1'b0;
        seq_total_ms = '0;
        seq_sweeps = '0;
        seq_phase = tsas_pkg::PH_SETTLE;
        seq_phase_ms = '0;
      end
      tsas_pkg::OP_CANCEL: begin
        seq_cancelled = 1'b1;
        seq_done = 1'b1;
        seq_success = 1'b0;
        seq_phase = tsas_pkg::PH_FAILED;
        seq_phase_ms = '0;
      end
      default: ;
    endcase
    s.phase = seq_phase;
    s.finished = seq_done;
    s.success = seq_success;
    s.push_active = (seq_phase == tsas_pkg::PH_PUSH) || (seq_phase == tsas_pkg::PH_HOLD);
    s.sweeps = seq_sweeps;
    return s;
  endfunction

  // ---- status monitor ----

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tsas_pkg::status_t want;
    if (rst_n && in_valid && !in_ready) input_stalls++;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        mismatches++;
        $display("%0t: status with no request outstanding, expected none, got phase %0d",
                 $time, out_phase_code);
      end else begin
        want = expected_status.pop_front();
        compare_field("phase_code", want.phase, out_phase_code);
        compare_field("finished", want.finished, out_finished);
        compare_field("success", want.success, out_success);
        compare_field("push_active", want.push_active, out_push_active);
        compare_field("sweeps_completed", want.sweeps, out_sweeps_completed);
        checked_count++;
        phases_seen[out_phase_code] = 1'b1;
      end
    end
  end

  // ---- status receiver: own stall pattern plus requested hold-off ----

  initial begin
    int unsigned run_left;
    int unsigned holdoff_left;
    bit          stalled;
    run_left = 0;
    holdoff_left = 0;
    stalled = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req > 0) begin
        holdoff_left = holdoff_req;
        holdoff_req = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (stall_max == 0) begin
        out_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          stalled = !stalled;
          run_left = stalled ? $urandom_range(1, stall_max) : $urandom_range(1, 12);
        end
        run_left--;
        out_ready <= !stalled;
      end
    end
  end

  // ---- request side ----

  function automatic logic [tsas_pkg::ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return tsas_pkg::ELAPSED_W'($urandom_range(101, 255));
      default: return tsas_pkg::ELAPSED_W'($urandom_range(1, 100));
    endcase
  endfunction

  function automatic logic coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  function automatic logic [tsas_pkg::DUR_W-1:0] pick_duration();
    return ($urandom_range(0, 19) == 0) ? 16'hFFFF : tsas_pkg::DUR_W'($urandom_range(0, 300));
  endfunction

  // call at a falling edge; returns at a falling edge with valid possibly still up
  task automatic send_req(input tsas_pkg::opcode_t op,
                          input logic [tsas_pkg::ELAPSED_W-1:0] el, input logic cap);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_elapsed_ms <= el;
    in_captured <= cap;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (op != tsas_pkg::OP_NONE &&
        !(op == tsas_pkg::OP_TICK && (seq_done || seq_phase == tsas_pkg::PH_IDLE)))
      live_count++;
    expected_status.push_back(advance_sequence(op, el, cap));
    sent_count++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && gap_max > 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic wait_idle();
    drop_valid();
    while (expected_status.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input tsas_pkg::reg_idx_t idx,
                           input logic [tsas_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic load_config(input tsas_pkg::cfg_t c);
    wait_idle();
    write_reg(tsas_pkg::REG_SETTLE, tsas_pkg::CFG_W'(c.settle_ms));
    write_reg(tsas_pkg::REG_PUSH_OUT, tsas_pkg::CFG_W'(c.push_out_ms));
    write_reg(tsas_pkg::REG_HOLD, tsas_pkg::CFG_W'(c.hold_ms));
    write_reg(tsas_pkg::REG_CAPTURE, tsas_pkg::CFG_W'(c.capture_wait_ms));
    write_reg(tsas_pkg::REG_RETRACT, tsas_pkg::CFG_W'(c.retract_ms));
    write_reg(tsas_pkg::REG_BETWEEN, tsas_pkg::CFG_W'(c.between_ms));
    write_reg(tsas_pkg::REG_TIMEOUT, tsas_pkg::CFG_W'(c.timeout_ms));
    write_reg(tsas_pkg::REG_SWEEPS, tsas_pkg::CFG_W'(c.sweep_count));
    cfg_we <= 1'b0;
    seq_cfg = c;
    config_count++;
  endtask

  // ---- tests ----

  task automatic test_reset_state();
    gap_max = 3;
    stall_max = 4;
    send_req(tsas_pkg::OP_TICK, 8'd50, 1'b0);
    send_req(tsas_pkg::OP_NONE, 8'hFF, 1'b1);
    send_req(tsas_pkg::OP_CANCEL, 8'd0, 1'b0);
    send_req(tsas_pkg::OP_TICK, 8'd100, 1'b1);
    send_req(tsas_pkg::OP_START, 8'd0, 1'b0);
    send_req(tsas_pkg::OP_TICK, 8'hFF, 1'b1);
    send_req(tsas_pkg::OP_CANCEL, 8'd7, 1'b1);
  endtask

  task automatic test_zero_timeout();
    gap_max = 0;
    stall_max = 0;
    load_config(tsas_pkg::cfg_t'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 20'd0, 8'd0});
    send_req(tsas_pkg::OP_START, 8'd0, 1'b0);
    send_req(tsas_pkg::OP_TICK, 8'd0, 1'b0);
  endtask

  task automatic test_zero_sweeps();
    gap_max = 0;
    stall_max = 0;
    load_config(tsas_pkg::cfg_t'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 20'hFFFFF, 8'd0});
    send_req(tsas_pkg::OP_START, 8'd1, 1'b1);
    repeat (4) send_req(tsas_pkg::OP_TICK, 8'd1, 1'b0);
    send_req(tsas_pkg::OP_TICK, 8'd90, 1'b1);
    send_req(tsas_pkg::OP_START, 8'd0, 1'b0);
  endtask

  // a sensed capture cuts the hold short
  task automatic test_capture_hold();
    gap_max = 8;
    stall_max = 10;
    load_config(tsas_pkg::cfg_t'{16'd0, 16'd0, 16'd300, 16'd150, 16'd0, 16'd50, 20'd1000,
                                 8'd2});
    send_req(tsas_pkg::OP_START, 8'd0, 1'b0);
    send_req(tsas_pkg::OP_TICK, 8'd0, 1'b0);
    send_req(tsas_pkg::OP_TICK, 8'd0, 1'b0);
    send_req(tsas_pkg::OP_TICK, 8'd100, 1'b1);
    send_req(tsas_pkg::OP_TICK, 8'd60, 1'b0);
    send_req(tsas_pkg::OP_TICK, 8'd60, 1'b1);
    send_req(tsas_pkg::OP_TICK, 8'd0, 1'b0);
  endtask

  task automatic test_max_settings();
    gap_max = 2;
    stall_max = 0;
    load_config(tsas_pkg::cfg_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 20'hFFFFF, 8'hFF});
    send_req(tsas_pkg::OP_START, 8'hFF, 1'b1);
    send_req(tsas_pkg::OP_TICK, 8'hFF, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    gap_max = 0;
    stall_max = 0;
    load_config(tsas_pkg::cfg_t'{16'd50, 16'd50, 16'd100, 16'd40, 16'd50, 16'd30, 20'd3000,
                                 8'd3});
    holdoff_req = 48;
    send_req(tsas_pkg::OP_START, pick_elapsed(), coin());
    repeat (30) send_req(tsas_pkg::OP_TICK, pick_elapsed(), coin());
  endtask

  task automatic run_sweep(input tsas_pkg::cfg_t c, input bit noisy,
                           input int unsigned cap_items);
    int unsigned       n;
    int unsigned       roll;
    tsas_pkg::opcode_t op;
    load_config(c);
    if (noisy && $urandom_range(0, 3) == 0) send_req(tsas_pkg::OP_TICK, pick_elapsed(), coin());
    send_req(tsas_pkg::OP_START, pick_elapsed(), coin());
    n = 0;
    while (!seq_done && n < cap_items) begin
      roll = noisy ? $urandom_range(0, 99) : 99;
      if (roll < 2) op = tsas_pkg::OP_CANCEL;
      else if (roll < 4) op = tsas_pkg::OP_START;
      else if (roll < 7) op = tsas_pkg::OP_NONE;
      else op = tsas_pkg::OP_TICK;
      send_req(op, pick_elapsed(), coin());
      n++;
    end
    repeat ($urandom_range(0, 2)) send_req(tsas_pkg::OP_TICK, pick_elapsed(), coin());
  endtask

  task automatic test_random_sweeps();
    tsas_pkg::cfg_t c;
    // zero durations: every tick advances, so the sweep counter runs to the top
    gap_max = 2;
    stall_max = 3;
    run_sweep(tsas_pkg::cfg_t'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 20'hFFFFF, 8'hFF},
              1'b0, 1100);
    while (sent_count < 1320) begin
      c.settle_ms = pick_duration();
      c.push_out_ms = pick_duration();
      c.hold_ms = pick_duration();
      c.capture_wait_ms = pick_duration();
      c.retract_ms = pick_duration();
      c.between_ms = pick_duration();
      case ($urandom_range(0, 9))
        0, 1, 2: c.timeout_ms = tsas_pkg::TMO_W'($urandom_range(0, 600));
        9: c.timeout_ms = 20'hFFFFF;
        default: c.timeout_ms = tsas_pkg::TMO_W'($urandom_range(2000, 20000));
      endcase
      c.sweep_count = ($urandom_range(0, 9) == 0) ? 8'd0 :
                      tsas_pkg::CNT_W'($urandom_range(1, 4));
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 8;
      endcase
      case ($urandom_range(0, 2))
        0: stall_max = 0;
        1: stall_max = 4;
        default: stall_max = 10;
      endcase
      run_sweep(c, 1'b1, 150);
    end
  endtask

  task automatic finish_run();
    drop_valid();
    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_status.size() != 0) begin
      mismatches++;
      $display("%0t: %0d status(es) never arrived", $time, expected_status.size());
    end
    $display("%0d requests (%0d acting) over %0d register settings, %0d statuses checked",
             sent_count, live_count, config_count, checked_count);
    $display("phase codes reported (bit per code) %b, cycles with input held off %0d",
             phases_seen, input_stalls);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  endtask

  initial begin
    seq_cfg = tsas_pkg::cfg_t'{tsas_pkg::SETTLE_RST, tsas_pkg::PUSH_OUT_RST,
                               tsas_pkg::HOLD_RST, tsas_pkg::CAPTURE_RST,
                               tsas_pkg::RETRACT_RST, tsas_pkg::BETWEEN_RST,
                               tsas_pkg::TIMEOUT_RST, tsas_pkg::SWEEPS_RST};
    seq_phase = tsas_pkg::PH_IDLE;
    seq_phase_ms = '0;
    seq_total_ms = '0;
    seq_sweeps = '0;
    seq_done = 1'b0;
    seq_success = 1'b0;
    seq_cancelled = 1'b0;
    gap_max = 0;
    stall_max = 0;
    holdoff_req = 0;
    burst_left = 0;
    live_count = 0;
    sent_count = 0;
    checked_count = 0;
    config_count = 0;
    input_stalls = 0;
    mismatches = 0;
    cycle_count = 0;
    phases_seen = '0;
    valid_up = 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= tsas_pkg::REG_SETTLE;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_opcode <= tsas_pkg::OP_TICK;
    in_elapsed_ms <= '0;
    in_captured <= 1'b0;
    rst_n <= 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_zero_timeout();
    test_zero_sweeps();
    test_capture_hold();
    test_max_settings();
    test_backpressure();
    test_random_sweeps();
    finish_run();
  end

endmodule

[files.f]
+incdir+rtl
rtl/tsas_pkg.sv
rtl/tsas_cfg_regs.sv
rtl/tsas_core.sv
rtl/timed_sweep_actuator_sequencer.sv
rtl/tsas_checker.sv
tb/sv/tb_top.sv
